// ===== sv/rarsf_pkg.sv =====
// Shared types, constants and modular helpers for the Fenwick range-add / range-sum core.
// No dependencies.
package rarsf_pkg;

    localparam int unsigned RW = 11;
    localparam int unsigned VW = 30;
    localparam logic [VW-1:0] MODP = 30'd1000000007;

    localparam logic [1:0] MS_LO_NEG = 2'd0;
    localparam logic [1:0] MS_HI_X   = 2'd1;
    localparam logic [1:0] MS_S_HI   = 2'd2;
    localparam logic [1:0] MS_S_LO   = 2'd3;

    localparam logic [1:0] MD_C1  = 2'd0;
    localparam logic [1:0] MD_C2  = 2'd1;
    localparam logic [1:0] MD_THI = 2'd2;
    localparam logic [1:0] MD_TLO = 2'd3;

    typedef struct packed {
        logic       load;
        logic       clr_step;
        logic       mul_start;
        logic [1:0] mul_sel;
        logic       mul_cap;
        logic [1:0] mul_dst;
        logic       walk_init;
        logic       walk_hi;
        logic       walk_plus1;
        logic       mem_rd;
        logic       upd_wr;
        logic       upd_hi;
        logic       q_acc;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic op;
        logic nonempty;
        logic mul_done;
        logic add_end;
        logic q_end;
        logic out_free;
    } t_sts;

    function automatic logic [VW-1:0] madd(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [VW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, MODP}) ? VW'(s - {1'b0, MODP}) : s[VW-1:0];
    endfunction

    function automatic logic [VW-1:0] msub(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [VW:0] s;
        s = {1'b0, a} + {1'b0, MODP} - {1'b0, b};
        return (a >= b) ? (a - b) : s[VW-1:0];
    endfunction

endpackage

// ===== sv/rarsf_mulmod.sv =====
// Bit-serial modular multiplier: a * b mod P, MSB first, double then add.
// Depends on rarsf_pkg.
module rarsf_mulmod #(
    parameter int unsigned PW = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [rarsf_pkg::VW-1:0] i_a,
    input  logic [PW-1:0]         i_b,
    output logic                  o_done,
    output logic [rarsf_pkg::VW-1:0] o_prod
);
    import rarsf_pkg::*;

    localparam int unsigned CW = $clog2(PW);

    logic          r_busy;
    logic          r_done;
    logic          r_phase;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_acc;
    logic [VW-1:0] r_a;
    logic [PW-1:0] r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_phase && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc   <= '0;
            r_cnt   <= CW'(PW - 1);
            r_phase <= 1'b0;
            r_a     <= i_a;
            r_b     <= i_b;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_acc   <= madd(r_acc, r_acc);
                r_phase <= 1'b1;
            end else begin
                if (r_b[r_cnt]) begin
                    r_acc <= madd(r_acc, r_a);
                end
                r_cnt   <= r_cnt - 1'b1;
                r_phase <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== sv/rarsf_dp.sv =====
// Datapath: operand registers, tree memory (slope and offset side by side), walk node,
// sums and the output register. Depends on rarsf_pkg and rarsf_mulmod.
module rarsf_dp #(
    parameter int unsigned SIZE = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rarsf_pkg::t_cmd           i_cmd,
    output rarsf_pkg::t_sts           o_sts,
    input  logic                      i_opcode,
    input  logic [rarsf_pkg::RW-1:0]  i_range_start,
    input  logic [rarsf_pkg::RW-1:0]  i_range_end,
    input  logic [rarsf_pkg::VW-1:0]  i_addend,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [rarsf_pkg::VW-1:0]  o_range_total
);
    import rarsf_pkg::*;

    localparam int unsigned PW = $clog2(SIZE + 1);
    localparam int unsigned AW = $clog2(SIZE);
    localparam int unsigned NW = PW + 1;

    logic [2*VW-1:0] mem [SIZE];
    logic [2*VW-1:0] r_rd;
    logic [AW-1:0]   r_clr;
    logic            r_out_valid;
    logic [VW-1:0]   r_total;
    logic            r_op;
    logic [PW-1:0]   r_lo;
    logic [PW-1:0]   r_hi;
    logic [VW-1:0]   r_x;
    logic [VW-1:0]   r_negx;
    logic [VW-1:0]   r_c1;
    logic [VW-1:0]   r_c2;
    logic [VW-1:0]   r_s;
    logic [VW-1:0]   r_o;
    logic [VW-1:0]   r_thi;
    logic [VW-1:0]   r_tlo;
    logic [NW-1:0]   r_node;

    logic [PW-1:0]   lo_sat;
    logic [PW-1:0]   hi_sat;
    logic [VW-1:0]   x_red;
    logic [NW-1:0]   lowbit;
    logic [AW-1:0]   addr;
    logic [PW-1:0]   walk_p;
    logic [VW-1:0]   mul_a;
    logic [PW-1:0]   mul_b;
    logic            mul_done;
    logic [VW-1:0]   mul_prod;
    logic            nonempty;

    assign lo_sat = ({21'b0, i_range_start} > 32'(SIZE)) ? PW'(SIZE) : PW'(i_range_start);
    assign hi_sat = ({21'b0, i_range_end} > 32'(SIZE)) ? PW'(SIZE) : PW'(i_range_end);
    assign x_red  = (i_addend >= MODP) ? (i_addend - MODP) : i_addend;
    assign lowbit = r_node & (~r_node + 1'b1);
    assign addr   = AW'(r_node - 1'b1);
    assign walk_p = i_cmd.walk_hi ? r_hi : r_lo;
    assign nonempty = r_lo < r_hi;

    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_LO_NEG: begin mul_a = r_negx; mul_b = r_lo; end
            MS_HI_X:   begin mul_a = r_x;    mul_b = r_hi; end
            MS_S_HI:   begin mul_a = r_s;    mul_b = r_hi; end
            default:   begin mul_a = r_s;    mul_b = r_lo; end
        endcase
    end

    rarsf_mulmod #(.PW(PW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // tree memory, one write port shared by the clearing pass and updates
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem[r_clr] <= '0;
        end else if (i_cmd.upd_wr) begin
            mem[addr] <= {madd(r_rd[2*VW-1:VW], i_cmd.upd_hi ? r_negx : r_x),
                          madd(r_rd[VW-1:0],    i_cmd.upd_hi ? r_c2   : r_c1)};
        end
        if (i_cmd.mem_rd) begin
            r_rd <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_lo   <= lo_sat;
            r_hi   <= hi_sat;
            r_x    <= x_red;
            r_negx <= msub('0, x_red);
        end
        if (i_cmd.walk_init) begin
            r_node <= NW'({1'b0, walk_p}) + NW'(i_cmd.walk_plus1);
            r_s    <= '0;
            r_o    <= '0;
        end else if (i_cmd.upd_wr) begin
            r_node <= r_node + lowbit;
        end else if (i_cmd.q_acc) begin
            r_node <= r_node - lowbit;
            r_s    <= madd(r_s, r_rd[2*VW-1:VW]);
            r_o    <= madd(r_o, r_rd[VW-1:0]);
        end
        if (i_cmd.mul_cap) begin
            unique case (i_cmd.mul_dst)
                MD_C1:   r_c1  <= mul_prod;
                MD_C2:   r_c2  <= mul_prod;
                MD_THI:  r_thi <= madd(mul_prod, r_o);
                default: r_tlo <= madd(mul_prod, r_o);
            endcase
        end
        if (i_cmd.out_load) begin
            r_total <= nonempty ? msub(r_thi, r_tlo) : '0;
        end
    end

    assign o_sts.clr_last = (r_clr == AW'(SIZE - 1));
    assign o_sts.op       = r_op;
    assign o_sts.nonempty = nonempty;
    assign o_sts.mul_done = mul_done;
    assign o_sts.add_end  = r_node > NW'(SIZE);
    assign o_sts.q_end    = (r_node == '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_range_total = r_total;

endmodule

// ===== sv/rarsf_ctrl.sv =====
// Controller: clearing pass, operation sequencing and tree walks.
// Depends on rarsf_pkg.
module rarsf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  rarsf_pkg::t_sts i_sts,
    output rarsf_pkg::t_cmd o_cmd
);
    import rarsf_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_AM1  = 4'd3;
    localparam logic [3:0] S_AM1W = 4'd4;
    localparam logic [3:0] S_AM2  = 4'd5;
    localparam logic [3:0] S_AM2W = 4'd6;
    localparam logic [3:0] S_AWI  = 4'd7;
    localparam logic [3:0] S_ARD  = 4'd8;
    localparam logic [3:0] S_AWR  = 4'd9;
    localparam logic [3:0] S_QWI  = 4'd10;
    localparam logic [3:0] S_QRD  = 4'd11;
    localparam logic [3:0] S_QAC  = 4'd12;
    localparam logic [3:0] S_QM   = 4'd13;
    localparam logic [3:0] S_QMW  = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_ep;
    logic       n_ep;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_ep    = r_ep;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_ep = 1'b0;
                priority if (!i_sts.nonempty) begin
                    n_state = i_sts.op ? S_OUT : S_IDLE;
                end else if (i_sts.op) begin
                    n_state = S_QWI;
                end else begin
                    n_state = S_AM1;
                end
            end
            S_AM1: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_LO_NEG;
                n_state         = S_AM1W;
            end
            S_AM1W: begin
                if (i_sts.mul_done) begin
                    o_cmd.mul_cap = 1'b1;
                    o_cmd.mul_dst = MD_C1;
                    n_state       = S_AM2;
                end
            end
            S_AM2: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_HI_X;
                n_state         = S_AM2W;
            end
            S_AM2W: begin
                if (i_sts.mul_done) begin
                    o_cmd.mul_cap = 1'b1;
                    o_cmd.mul_dst = MD_C2;
                    n_state       = S_AWI;
                end
            end
            S_AWI: begin
                o_cmd.walk_init  = 1'b1;
                o_cmd.walk_hi    = r_ep;
                o_cmd.walk_plus1 = 1'b1;
                n_state          = S_ARD;
            end
            S_ARD: begin
                if (i_sts.add_end) begin
                    n_ep    = 1'b1;
                    n_state = r_ep ? S_IDLE : S_AWI;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = S_AWR;
                end
            end
            S_AWR: begin
                o_cmd.upd_wr = 1'b1;
                o_cmd.upd_hi = r_ep;
                n_state      = S_ARD;
            end
            S_QWI: begin
                o_cmd.walk_init = 1'b1;
                o_cmd.walk_hi   = !r_ep;
                n_state         = S_QRD;
            end
            S_QRD: begin
                if (i_sts.q_end) begin
                    n_state = S_QM;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = S_QAC;
                end
            end
            S_QAC: begin
                o_cmd.q_acc = 1'b1;
                n_state     = S_QRD;
            end
            S_QM: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = r_ep ? MS_S_LO : MS_S_HI;
                n_state         = S_QMW;
            end
            S_QMW: begin
                if (i_sts.mul_done) begin
                    o_cmd.mul_cap = 1'b1;
                    o_cmd.mul_dst = r_ep ? MD_TLO : MD_THI;
                    n_ep          = 1'b1;
                    n_state       = r_ep ? S_OUT : S_QWI;
                end
            end
            default: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ep    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ep    <= n_ep;
        end
    end

endmodule

// ===== sv/range_add_range_sum_fenwick_mod_core.sv =====
// Top level: modular range-add / range-sum over two Fenwick trees.
// Depends on rarsf_pkg, rarsf_ctrl, rarsf_dp (and rarsf_mulmod below it).
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+------------------------------------------------
//  in      | i_in_valid | o_in_stall  | i_opcode, i_range_start, i_range_end, i_addend
//  out     | o_out_valid| i_out_stall | o_range_total
//
// After reset a clearing pass writes SIZE tree rows, one per cycle, with the input stalled.
// One item at a time. Add: two bit-serial mod multiplies (PW = clog2(SIZE+1) multiplier
// bits each), then two read-modify-write walks, each tree node read and then written.
// Query: two walks, each node read and then accumulated, each walk followed by one multiply.
// An empty add range goes straight back to idle and an empty query outputs zero; for a
// nonempty range the serial multiplier and single memory port set how long an item takes.
// A finished result waits in the output register while the next item is taken; a query
// that finds that register full and stalled holds in its last state with the input stalled.
module range_add_range_sum_fenwick_mod_core #(
    parameter int unsigned SIZE = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_opcode,
    input  logic [rarsf_pkg::RW-1:0] i_range_start,
    input  logic [rarsf_pkg::RW-1:0] i_range_end,
    input  logic [rarsf_pkg::VW-1:0] i_addend,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [rarsf_pkg::VW-1:0] o_range_total
);
    import rarsf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rarsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rarsf_dp #(.SIZE(SIZE)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (i_opcode),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .i_addend      (i_addend),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_range_total (o_range_total)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> sts.out_free) else $error("result overwritten");

    a_write_in_tree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.upd_wr |-> !sts.add_end) else $error("tree write past last node");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_step |-> o_in_stall) else $error("item taken during clearing pass");

    a_mul_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mul_start |=> !sts.mul_done) else $error("multiplier done too early");

endmodule
